[rtl/grc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grc_pkg: shared constants and types for the grid reachability checker
// Grid sizes, cell codes, register indexes, the search engine's state type
// and the control words passed between the top level and the search engine.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int NCELLS   = MAX_ROWS * MAX_COLS;
  localparam int IDX_W    = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int CNT_W    = IDX_W + 1;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CFG_W    = 7;
  localparam int KIND_W   = 3;
  localparam int OUT_CNT_W = 13;

  localparam logic [KIND_W-1:0] KIND_FLOOR   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WALL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_COLLECT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EXIT    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_START   = 3'd4;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(64);
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(64);

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
  } pos_t;

  localparam int POS_W = IDX_W + ROW_W + COL_W;

  typedef struct packed {
    logic             go;
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    logic [CNT_W-1:0] loaded;
    logic [IDX_W-1:0] start_idx;
    logic             start_seen;
  } srch_cmd_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] reached;
    logic             exit_hit;
  } srch_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DIV,
    S_CAND_RD,
    S_CAND_CHK,
    S_NB,
    S_POP,
    S_POP_WAIT,
    S_POP_KIND,
    S_DONE
  } srch_state_t;

endpackage
`default_nettype wire

[rtl/grc_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grc_in_if: cell word channel
// Carries one grid cell per word, with the flag that closes the grid.
// ----------------------------------------------------------------------------
interface grc_in_if;
  logic                      valid;
  logic                      ready;
  logic [grc_pkg::KIND_W-1:0] cell_kind;
  logic                      last_cell;

  modport source (output valid, output cell_kind, output last_cell, input ready);
  modport sink   (input valid, input cell_kind, input last_cell, output ready);
endinterface

// Result channel: one word per completed grid.
interface grc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          path_ok;
  logic                          exit_reachable;
  logic [grc_pkg::OUT_CNT_W-1:0] collectibles_total;
  logic [grc_pkg::OUT_CNT_W-1:0] collectibles_reached;
  logic                          start_found;

  modport source (output valid, output path_ok, output exit_reachable,
                  output collectibles_total, output collectibles_reached,
                  output start_found, input ready);
  modport sink   (input valid, input path_ok, input exit_reachable,
                  input collectibles_total, input collectibles_reached,
                  input start_found, output ready);
endinterface
`default_nettype wire

[rtl/grc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grc_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module grc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/grc_search.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grc_search: flood fill engine
// Holds the cell store, the visited marks and the search stack, and runs
// two depth-first fills from the start cell, one memory access step a cycle.
// ----------------------------------------------------------------------------
module grc_search (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       load_we,
  input  wire logic [grc_pkg::IDX_W-1:0]  load_addr,
  input  wire logic [grc_pkg::KIND_W-1:0] load_kind,
  input  wire grc_pkg::srch_cmd_t         cmd,
  output grc_pkg::srch_res_t              res
);
  import grc_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NCELLS - 1);

  srch_state_t      state, state_next;
  srch_cmd_t        job;
  logic             fill;
  logic             seeding;
  logic [IDX_W-1:0] clr_addr;
  logic [IDX_W-1:0] rem;
  logic [ROW_W-1:0] quo;
  pos_t             cur, cand, nb_pos;
  logic [1:0]       nb;
  logic [CNT_W-1:0] sp;
  logic [CNT_W-1:0] reached;
  logic             exit_hit;

  logic              cell_we_unused;
  logic [IDX_W-1:0]  cell_raddr;
  logic [KIND_W-1:0] cell_rdata;
  logic              vis_we;
  logic [IDX_W-1:0]  vis_waddr;
  logic [1:0]        vis_wdata, vis_rdata;
  logic              stk_we;
  logic [POS_W-1:0]  stk_rdata;
  pos_t              stk_top;

  logic             nb_ok, nb_in, push, start_in, div_step;
  logic [CNT_W-1:0] nb_wide;
  logic [CNT_W-1:0] sp_dec;

  assign cell_we_unused = 1'b0;
  assign stk_top = pos_t'(stk_rdata);
  assign sp_dec  = sp - CNT_W'(1);

  grc_ram #(.W(KIND_W), .D(NCELLS)) u_cells (
    .clk(clk), .we(load_we | cell_we_unused), .waddr(load_addr), .wdata(load_kind),
    .raddr(cell_raddr), .rdata(cell_rdata)
  );

  grc_ram #(.W(2), .D(NCELLS)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(cand.idx), .rdata(vis_rdata)
  );

  grc_ram #(.W(POS_W), .D(NCELLS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(sp[IDX_W-1:0]), .wdata(cand),
    .raddr(sp_dec[IDX_W-1:0]), .rdata(stk_rdata)
  );

  // Neighbour of the current cell selected by nb: up, down, left, right.
  always_comb begin
    nb_pos  = cur;
    nb_ok   = 1'b0;
    nb_wide = {1'b0, cur.idx};
    unique case (nb)
      2'd0: begin
        nb_ok   = (cur.r != '0);
        nb_wide = {1'b0, cur.idx} - CNT_W'(job.cols);
        nb_pos.r = cur.r - ROW_W'(1);
      end
      2'd1: begin
        nb_ok   = (CFG_W'(cur.r) + CFG_W'(1)) < job.rows;
        nb_wide = {1'b0, cur.idx} + CNT_W'(job.cols);
        nb_pos.r = cur.r + ROW_W'(1);
      end
      2'd2: begin
        nb_ok   = (cur.c != '0);
        nb_wide = {1'b0, cur.idx} - CNT_W'(1);
        nb_pos.c = cur.c - COL_W'(1);
      end
      default: begin
        nb_ok   = (CFG_W'(cur.c) + CFG_W'(1)) < job.cols;
        nb_wide = {1'b0, cur.idx} + CNT_W'(1);
        nb_pos.c = cur.c + COL_W'(1);
      end
    endcase
    nb_pos.idx = nb_wide[IDX_W-1:0];
    nb_in = nb_ok && (nb_wide < job.loaded);
  end

  assign push = !vis_rdata[fill] && (cell_rdata != KIND_WALL) &&
                !(!fill && (cell_rdata == KIND_EXIT));
  assign start_in = job.start_seen && ({1'b0, job.start_idx} < job.loaded);
  assign div_step = (rem >= IDX_W'(job.cols));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (cmd.go) state_next = S_CLEAR;
      S_CLEAR:    if (clr_addr == IDX_LAST) state_next = start_in ? S_DIV : S_DONE;
      S_DIV:      if (!div_step) state_next = S_CAND_RD;
      S_CAND_RD:  state_next = S_CAND_CHK;
      S_CAND_CHK: state_next = (seeding || nb == 2'd3) ? S_POP : S_NB;
      S_NB: begin
        if (nb_in) state_next = S_CAND_RD;
        else if (nb == 2'd3) state_next = S_POP;
      end
      S_POP: begin
        if (sp != '0) state_next = S_POP_WAIT;
        else state_next = fill ? S_DONE : S_CAND_RD;
      end
      S_POP_WAIT: state_next = S_POP_KIND;
      S_POP_KIND: state_next = S_NB;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cell_raddr = cand.idx;
    vis_we     = 1'b0;
    vis_waddr  = cand.idx;
    vis_wdata  = fill ? {1'b1, vis_rdata[0]} : {vis_rdata[1], 1'b1};
    stk_we     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_addr;
        vis_wdata = 2'b00;
      end
      S_CAND_CHK: begin
        vis_we = push;
        stk_we = push;
      end
      S_POP_WAIT: cell_raddr = stk_top.idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp   <= '0;
      fill <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.go) begin
            job      <= cmd;
            clr_addr <= '0;
            fill     <= 1'b0;
            sp       <= '0;
            reached  <= '0;
            exit_hit <= 1'b0;
            rem      <= cmd.start_idx;
            quo      <= '0;
          end
        end
        S_CLEAR: clr_addr <= clr_addr + IDX_W'(1);
        S_DIV: begin
          if (div_step) begin
            rem <= rem - IDX_W'(job.cols);
            quo <= quo + ROW_W'(1);
          end else begin
            cand    <= '{idx: job.start_idx, r: quo, c: rem[COL_W-1:0]};
            seeding <= 1'b1;
          end
        end
        S_CAND_CHK: begin
          if (push) sp <= sp + CNT_W'(1);
          seeding <= 1'b0;
          if (!seeding) nb <= nb + 2'd1;
        end
        S_NB: begin
          if (nb_in) cand <= nb_pos;
          else nb <= nb + 2'd1;
        end
        S_POP: begin
          if (sp != '0) begin
            sp <= sp_dec;
          end else if (!fill) begin
            fill    <= 1'b1;
            seeding <= 1'b1;
            cand    <= '{idx: job.start_idx, r: quo, c: rem[COL_W-1:0]};
          end
        end
        S_POP_WAIT: cur <= stk_top;
        S_POP_KIND: begin
          if (!fill && cell_rdata == KIND_COLLECT) reached <= reached + CNT_W'(1);
          if (fill && cell_rdata == KIND_EXIT) exit_hit <= 1'b1;
          nb <= 2'd0;
        end
        default: ;
      endcase
    end
  end

  assign res.valid    = (state == S_DONE);
  assign res.reached  = reached;
  assign res.exit_hit = exit_hit;

  // Each cell is pushed at most once per fill, so the stack cannot overrun.
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= CNT_W'(NCELLS)) else $error("search stack overrun");
  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.go |-> state == S_IDLE) else $error("search started while busy");
  a_pop_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == S_POP_KIND |-> {1'b0, cur.idx} < job.loaded)
    else $error("popped cell lies outside the loaded grid");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    res.valid |=> !res.valid) else $error("done held longer than one cycle");
endmodule
`default_nettype wire

[rtl/grid_reachability_check.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grid_reachability_check: grid loader and flood fill reachability checker
// Loads a grid one cell per word, then checks that the start reaches every
// collectible (exits blocking) and at least one exit (exits passable).
// ----------------------------------------------------------------------------
//
//  channel   role    contents
//  -------   -----   ---------------------------------------------------------
//  grid      sink    cell_kind, last_cell: one cell per word, raster order
//  result    source  path_ok, exit_reachable, collectible counts, start_found
//  cfg       write   cfg_we, cfg_index, cfg_data: rows_in_use, cols_in_use
//
// Cell words are taken one per cycle. The word carrying last_cell starts the
// search: a clearing pass over all NCELLS visited marks (4096 for the 64 by
// 64 maximum), a start-position division by repeated subtraction, then the
// two fills, each stepping through the one-read-port memory access
// sequence. While the search runs no word is taken; a pending result only
// holds back a word that ends the next grid. Reset is synchronous and clears
// all control.
//
module grid_reachability_check (
  input  wire logic                          clk,
  input  wire logic                          rst,
  grc_in_if.sink                             grid,
  grc_out_if.source                          result,
  input  wire logic                          cfg_we,
  input  wire logic [grc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [grc_pkg::CFG_W-1:0]     cfg_data
);
  import grc_pkg::*;

  localparam logic [CFG_W-1:0] ROWS_MAX = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] COLS_MAX = CFG_W'(MAX_COLS);

  logic [CFG_W-1:0]   rows_cfg, cols_cfg, rows_eff, cols_eff;
  logic [2*CFG_W-1:0] prod;
  logic [CNT_W-1:0]   cells;

  logic [CNT_W-1:0] load_pos, load_pos_next, loaded;
  logic [CNT_W-1:0] total, total_next;
  logic [IDX_W-1:0] start_idx, start_idx_next;
  logic             start_seen, start_seen_next;
  logic             searching;
  logic [CNT_W-1:0] snap_total;
  logic             snap_start;
  logic             accept, store;

  srch_cmd_t cmd;
  srch_res_t res;

  // Configuration registers. Out-of-range sizes are clamped on use.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= ROWS_RESET;
      cols_cfg <= COLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: rows_cfg <= cfg_data;
        REG_COLS: cols_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows_eff = (rows_cfg == '0) ? CFG_W'(1) : (rows_cfg > ROWS_MAX) ? ROWS_MAX : rows_cfg;
  assign cols_eff = (cols_cfg == '0) ? CFG_W'(1) : (cols_cfg > COLS_MAX) ? COLS_MAX : cols_cfg;
  assign prod  = rows_eff * cols_eff;
  assign cells = prod[CNT_W-1:0];

  // Cells past the end of the grid are dropped, though their last flag counts.
  assign grid.ready = !searching && !(result.valid && grid.last_cell);
  assign accept     = grid.valid && grid.ready;
  assign store      = accept && (load_pos < cells);

  always_comb begin
    load_pos_next   = load_pos;
    total_next      = total;
    start_idx_next  = start_idx;
    start_seen_next = start_seen;
    if (store) begin
      load_pos_next = load_pos + CNT_W'(1);
      if (grid.cell_kind == KIND_COLLECT) total_next = total + CNT_W'(1);
      if (grid.cell_kind == KIND_START) begin
        start_idx_next  = load_pos[IDX_W-1:0];
        start_seen_next = 1'b1;
      end
    end
  end

  assign loaded = (load_pos_next < cells) ? load_pos_next : cells;

  assign cmd.go         = accept && grid.last_cell;
  assign cmd.rows       = rows_eff;
  assign cmd.cols       = cols_eff;
  assign cmd.loaded     = loaded;
  assign cmd.start_idx  = start_idx_next;
  assign cmd.start_seen = start_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos   <= '0;
      total      <= '0;
      start_idx  <= '0;
      start_seen <= 1'b0;
      searching  <= 1'b0;
    end else begin
      if (cmd.go) begin
        // The grid is handed over; load state restarts for the next one.
        load_pos   <= '0;
        total      <= '0;
        start_idx  <= '0;
        start_seen <= 1'b0;
        searching  <= 1'b1;
      end else begin
        load_pos   <= load_pos_next;
        total      <= total_next;
        start_idx  <= start_idx_next;
        start_seen <= start_seen_next;
        if (res.valid) searching <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      snap_total <= total_next;
      snap_start <= start_seen_next;
    end
  end

  grc_search u_search (
    .clk(clk), .rst(rst),
    .load_we(store), .load_addr(load_pos[IDX_W-1:0]), .load_kind(grid.cell_kind),
    .cmd(cmd), .res(res)
  );

  // Result register: holds the word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res.valid) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      result.path_ok        <= snap_start && res.exit_hit && (res.reached == snap_total);
      result.exit_reachable <= res.exit_hit;
      result.collectibles_total   <= snap_total[OUT_CNT_W-1:0];
      result.collectibles_reached <= res.reached[OUT_CNT_W-1:0];
      result.start_found    <= snap_start;
    end
  end

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    searching |-> !grid.ready) else $error("cell word taken during a search");
  a_res_in_search: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> searching) else $error("search result without a search");
  a_go_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.go |=> searching) else $error("last cell did not start a search");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !result.valid) else $error("pending result overwritten");
endmodule
`default_nettype wire
